// ===== hdl/ch64_pkg.sv =====
// Types, constants and microcode ROM for the short-message CityHash64 block.
// No dependencies; imported by every other file of the block but ch64_if.
package ch64_pkg;

  localparam int unsigned MaxLen = 64;
  localparam int unsigned AddrW  = $clog2(MaxLen);
  localparam int unsigned LenW   = $clog2(MaxLen) + 1;

  localparam logic [63:0] K0 = 64'hc3a5c85c97cb3127;
  localparam logic [63:0] K1 = 64'hb492b66fbe98f273;
  localparam logic [63:0] K2 = 64'h9ae16a3b2f90404f;

  typedef logic [3:0] reg_t;

  localparam reg_t RM  = 4'd0;
  localparam reg_t R1  = 4'd1;
  localparam reg_t R2  = 4'd2;
  localparam reg_t R3  = 4'd3;
  localparam reg_t R4  = 4'd4;
  localparam reg_t R5  = 4'd5;
  localparam reg_t R6  = 4'd6;
  localparam reg_t R7  = 4'd7;
  localparam reg_t R8  = 4'd8;
  localparam reg_t R9  = 4'd9;
  localparam reg_t R10 = 4'd10;
  localparam reg_t R11 = 4'd11;
  localparam reg_t R12 = 4'd12;
  localparam reg_t R13 = 4'd13;
  localparam reg_t R14 = 4'd14;
  localparam reg_t R15 = 4'd15;

  typedef enum logic [1:0] {ST_COLLECT, ST_HASH, ST_OUT} top_state_e;
  typedef enum logic [2:0] {CS_IDLE, CS_FETCH, CS_EXEC, CS_MUL, CS_LOAD} core_state_e;
  typedef enum logic [2:0] {PATH_0, PATH_3, PATH_7, PATH_16, PATH_32, PATH_64} path_e;
  typedef enum logic [3:0] {
    OP_ADD, OP_XOR, OP_MUL, OP_ROT, OP_SMIX, OP_BSWAP, OP_MOVB, OP_LD, OP_DONE
  } op_e;
  typedef enum logic [3:0] {
    BK_REG, BK_K0, BK_K1, BK_K2, BK_C1, BK_C4, BK_C8, BK_C9, BK_C256, BK_LEN
  } bsel_e;
  typedef enum logic [1:0] {LSZ_1, LSZ_4, LSZ_8} lsz_e;
  typedef enum logic [1:0] {BASE_ZERO, BASE_LEN, BASE_HALF} base_e;

  typedef struct packed {
    op_e         op;
    reg_t        dst;
    reg_t        ra;
    reg_t        rb;
    bsel_e       bsel;
    logic [5:0]  rot;
    lsz_e        lsz;
    base_e       base;
    logic [6:0]  off;
  } instr_t;

  typedef struct packed {
    logic            start;
    logic [LenW-1:0] len;
    path_e           path;
  } ch64_cmd_t;

  typedef struct packed {
    logic        done;
    logic [63:0] hash;
  } ch64_rsp_t;

  function automatic instr_t i_alu(op_e op, reg_t d, reg_t a, bsel_e bs, reg_t b,
                                   logic [5:0] r);
    instr_t i;
    i.op   = op;
    i.dst  = d;
    i.ra   = a;
    i.rb   = b;
    i.bsel = bs;
    i.rot  = r;
    i.lsz  = LSZ_8;
    i.base = BASE_ZERO;
    i.off  = 7'd0;
    return i;
  endfunction

  function automatic instr_t i_add(reg_t d, reg_t a, reg_t b);
    return i_alu(OP_ADD, d, a, BK_REG, b, 6'd0);
  endfunction

  function automatic instr_t i_addk(reg_t d, reg_t a, bsel_e k);
    return i_alu(OP_ADD, d, a, k, RM, 6'd0);
  endfunction

  function automatic instr_t i_xor(reg_t d, reg_t a, reg_t b);
    return i_alu(OP_XOR, d, a, BK_REG, b, 6'd0);
  endfunction

  function automatic instr_t i_mul(reg_t d, reg_t a, reg_t b);
    return i_alu(OP_MUL, d, a, BK_REG, b, 6'd0);
  endfunction

  function automatic instr_t i_mulk(reg_t d, reg_t a, bsel_e k);
    return i_alu(OP_MUL, d, a, k, RM, 6'd0);
  endfunction

  function automatic instr_t i_rot(reg_t d, reg_t a, logic [5:0] r);
    return i_alu(OP_ROT, d, a, BK_REG, RM, r);
  endfunction

  function automatic instr_t i_smix(reg_t d, reg_t a);
    return i_alu(OP_SMIX, d, a, BK_REG, RM, 6'd0);
  endfunction

  function automatic instr_t i_bswap(reg_t d, reg_t a);
    return i_alu(OP_BSWAP, d, a, BK_REG, RM, 6'd0);
  endfunction

  function automatic instr_t i_movk(reg_t d, bsel_e k);
    return i_alu(OP_MOVB, d, RM, k, RM, 6'd0);
  endfunction

  function automatic instr_t i_done(reg_t a);
    return i_alu(OP_DONE, RM, a, BK_REG, RM, 6'd0);
  endfunction

  function automatic instr_t i_ld(reg_t d, lsz_e s, base_e bs, logic [6:0] off);
    instr_t i;
    i      = i_alu(OP_LD, d, RM, BK_REG, RM, 6'd0);
    i.lsz  = s;
    i.base = bs;
    i.off  = off;
    return i;
  endfunction

  function automatic instr_t ucode(path_e p, logic [5:0] pc);
    instr_t i;
    i = i_done(RM);
    case (p)
      PATH_0: begin
        case (pc)
          6'd0:    i = i_movk(R1, BK_K2);
          6'd1:    i = i_done(R1);
          default: i = i_done(RM);
        endcase
      end
      PATH_3: begin
        case (pc)
          6'd0:    i = i_ld(R1, LSZ_1, BASE_ZERO, 7'd0);
          6'd1:    i = i_ld(R2, LSZ_1, BASE_HALF, 7'd0);
          6'd2:    i = i_ld(R3, LSZ_1, BASE_LEN, 7'(-1));
          6'd3:    i = i_mulk(R2, R2, BK_C256);
          6'd4:    i = i_add(R2, R2, R1);
          6'd5:    i = i_mulk(R3, R3, BK_C4);
          6'd6:    i = i_addk(R3, R3, BK_LEN);
          6'd7:    i = i_mulk(R2, R2, BK_K2);
          6'd8:    i = i_mulk(R3, R3, BK_K0);
          6'd9:    i = i_xor(R2, R2, R3);
          6'd10:   i = i_smix(R2, R2);
          6'd11:   i = i_mulk(R2, R2, BK_K2);
          6'd12:   i = i_done(R2);
          default: i = i_done(RM);
        endcase
      end
      PATH_7: begin
        case (pc)
          6'd0:    i = i_movk(RM, BK_LEN);
          6'd1:    i = i_add(RM, RM, RM);
          6'd2:    i = i_addk(RM, RM, BK_K2);
          6'd3:    i = i_ld(R1, LSZ_4, BASE_ZERO, 7'd0);
          6'd4:    i = i_mulk(R1, R1, BK_C8);
          6'd5:    i = i_addk(R1, R1, BK_LEN);
          6'd6:    i = i_ld(R2, LSZ_4, BASE_LEN, 7'(-4));
          6'd7:    i = i_xor(R3, R1, R2);
          6'd8:    i = i_mul(R3, R3, RM);
          6'd9:    i = i_smix(R3, R3);
          6'd10:   i = i_xor(R3, R2, R3);
          6'd11:   i = i_mul(R3, R3, RM);
          6'd12:   i = i_smix(R3, R3);
          6'd13:   i = i_mul(R3, R3, RM);
          6'd14:   i = i_done(R3);
          default: i = i_done(RM);
        endcase
      end
      PATH_16: begin
        case (pc)
          6'd0:    i = i_movk(RM, BK_LEN);
          6'd1:    i = i_add(RM, RM, RM);
          6'd2:    i = i_addk(RM, RM, BK_K2);
          6'd3:    i = i_ld(R1, LSZ_8, BASE_ZERO, 7'd0);
          6'd4:    i = i_addk(R1, R1, BK_K2);
          6'd5:    i = i_ld(R2, LSZ_8, BASE_LEN, 7'(-8));
          6'd6:    i = i_rot(R3, R2, 6'd37);
          6'd7:    i = i_mul(R3, R3, RM);
          6'd8:    i = i_add(R3, R3, R1);
          6'd9:    i = i_rot(R4, R1, 6'd25);
          6'd10:   i = i_add(R4, R4, R2);
          6'd11:   i = i_mul(R4, R4, RM);
          6'd12:   i = i_xor(R5, R3, R4);
          6'd13:   i = i_mul(R5, R5, RM);
          6'd14:   i = i_smix(R5, R5);
          6'd15:   i = i_xor(R5, R4, R5);
          6'd16:   i = i_mul(R5, R5, RM);
          6'd17:   i = i_smix(R5, R5);
          6'd18:   i = i_mul(R5, R5, RM);
          6'd19:   i = i_done(R5);
          default: i = i_done(RM);
        endcase
      end
      PATH_32: begin
        case (pc)
          6'd0:    i = i_movk(RM, BK_LEN);
          6'd1:    i = i_add(RM, RM, RM);
          6'd2:    i = i_addk(RM, RM, BK_K2);
          6'd3:    i = i_ld(R1, LSZ_8, BASE_ZERO, 7'd0);
          6'd4:    i = i_mulk(R1, R1, BK_K1);
          6'd5:    i = i_ld(R2, LSZ_8, BASE_ZERO, 7'd8);
          6'd6:    i = i_ld(R3, LSZ_8, BASE_LEN, 7'(-8));
          6'd7:    i = i_mul(R3, R3, RM);
          6'd8:    i = i_ld(R4, LSZ_8, BASE_LEN, 7'(-16));
          6'd9:    i = i_mulk(R4, R4, BK_K2);
          6'd10:   i = i_add(R5, R1, R2);
          6'd11:   i = i_rot(R5, R5, 6'd43);
          6'd12:   i = i_rot(R6, R3, 6'd30);
          6'd13:   i = i_add(R5, R5, R6);
          6'd14:   i = i_add(R5, R5, R4);
          6'd15:   i = i_addk(R6, R2, BK_K2);
          6'd16:   i = i_rot(R6, R6, 6'd18);
          6'd17:   i = i_add(R6, R6, R1);
          6'd18:   i = i_add(R6, R6, R3);
          6'd19:   i = i_xor(R7, R5, R6);
          6'd20:   i = i_mul(R7, R7, RM);
          6'd21:   i = i_smix(R7, R7);
          6'd22:   i = i_xor(R7, R6, R7);
          6'd23:   i = i_mul(R7, R7, RM);
          6'd24:   i = i_smix(R7, R7);
          6'd25:   i = i_mul(R7, R7, RM);
          6'd26:   i = i_done(R7);
          default: i = i_done(RM);
        endcase
      end
      PATH_64: begin
        case (pc)
          6'd0:    i = i_movk(RM, BK_LEN);
          6'd1:    i = i_add(RM, RM, RM);
          6'd2:    i = i_addk(RM, RM, BK_K2);
          6'd3:    i = i_ld(R1, LSZ_8, BASE_ZERO, 7'd0);
          6'd4:    i = i_mulk(R1, R1, BK_K2);
          6'd5:    i = i_ld(R2, LSZ_8, BASE_ZERO, 7'd8);
          6'd6:    i = i_ld(R3, LSZ_8, BASE_LEN, 7'(-24));
          6'd7:    i = i_ld(R4, LSZ_8, BASE_LEN, 7'(-32));
          6'd8:    i = i_ld(R5, LSZ_8, BASE_ZERO, 7'd16);
          6'd9:    i = i_mulk(R5, R5, BK_K2);
          6'd10:   i = i_ld(R6, LSZ_8, BASE_ZERO, 7'd24);
          6'd11:   i = i_mulk(R6, R6, BK_C9);
          6'd12:   i = i_ld(R7, LSZ_8, BASE_LEN, 7'(-8));
          6'd13:   i = i_ld(R8, LSZ_8, BASE_LEN, 7'(-16));
          6'd14:   i = i_mul(R8, R8, RM);
          6'd15:   i = i_add(R9, R1, R7);
          6'd16:   i = i_rot(R10, R9, 6'd43);
          6'd17:   i = i_rot(R11, R2, 6'd30);
          6'd18:   i = i_add(R11, R11, R3);
          6'd19:   i = i_mulk(R11, R11, BK_C9);
          6'd20:   i = i_add(R10, R10, R11);
          6'd21:   i = i_xor(R9, R9, R4);
          6'd22:   i = i_add(R9, R9, R6);
          6'd23:   i = i_addk(R9, R9, BK_C1);
          6'd24:   i = i_add(R11, R10, R9);
          6'd25:   i = i_mul(R11, R11, RM);
          6'd26:   i = i_bswap(R11, R11);
          6'd27:   i = i_add(R11, R11, R8);
          6'd28:   i = i_add(R10, R5, R6);
          6'd29:   i = i_rot(R10, R10, 6'd42);
          6'd30:   i = i_add(R10, R10, R3);
          6'd31:   i = i_add(R12, R9, R11);
          6'd32:   i = i_mul(R12, R12, RM);
          6'd33:   i = i_bswap(R12, R12);
          6'd34:   i = i_add(R12, R12, R7);
          6'd35:   i = i_mul(R12, R12, RM);
          6'd36:   i = i_add(R13, R5, R6);
          6'd37:   i = i_add(R13, R13, R3);
          6'd38:   i = i_add(R14, R10, R13);
          6'd39:   i = i_mul(R14, R14, RM);
          6'd40:   i = i_add(R14, R14, R12);
          6'd41:   i = i_bswap(R14, R14);
          6'd42:   i = i_add(R14, R14, R2);
          6'd43:   i = i_add(R15, R13, R14);
          6'd44:   i = i_mul(R15, R15, RM);
          6'd45:   i = i_add(R15, R15, R4);
          6'd46:   i = i_add(R15, R15, R8);
          6'd47:   i = i_smix(R15, R15);
          6'd48:   i = i_mul(R15, R15, RM);
          6'd49:   i = i_add(R15, R15, R10);
          6'd50:   i = i_done(R15);
          default: i = i_done(RM);
        endcase
      end
      default: i = i_done(RM);
    endcase
    return i;
  endfunction

endpackage

// ===== hdl/ch64_if.sv =====
// Valid/ready channel interfaces for message bytes in and hash words out.
// No dependencies.
interface ch64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface ch64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  logic        too_long;

  modport source (output valid, hash_value, too_long, input ready);
  modport sink (input valid, hash_value, too_long, output ready);
endinterface

// ===== hdl/cityhash64_short_message.sv =====
// CityHash64 (v1.1) of messages up to 64 bytes, a byte word per cycle if ready.
// Depends on ch64_pkg, ch64_if and ch64_core.
// Bytes are taken one per cycle while ready into a 64-entry buffer; an item
// without a byte may end an empty message. After the last word the block stops
// taking input while a microcoded sequencer computes the hash on one shared ALU
// and one 64-bit multiplier built from a 32x32 unit. Hash time is dominated by
// the multiplies and by 8-byte loads, which read their bytes one at a time
// through the single buffer read port.
// A message longer than 64 bytes returns hash 0 with too_long set, in the cycle
// after its last word is taken.
module cityhash64_short_message (
  input  logic       clk_i,
  input  logic       rst_ni,
  ch64_in_if.sink    in_i,
  ch64_out_if.source out_o
);
  import ch64_pkg::*;

  top_state_e       st_q, st_d;
  logic [LenW-1:0]  cnt_q, cnt_d, cnt_after;
  logic             ovf_q, ovf_d, ovf_after;
  logic [63:0]      hash_q, hash_d;
  logic             tl_q, tl_d;
  logic             acc, store;
  logic [7:0]       mem [MaxLen];
  logic [7:0]       rdata_q;
  logic [AddrW-1:0] raddr;
  ch64_cmd_t        cmd;
  ch64_rsp_t        rsp;

  assign in_i.ready = (st_q == ST_COLLECT);
  assign acc        = in_i.valid & in_i.ready;
  assign store      = in_i.has_byte && (cnt_q < LenW'(MaxLen));
  assign cnt_after  = cnt_q + LenW'(store);
  assign ovf_after  = ovf_q | (in_i.has_byte & ~store);

  always_ff @(posedge clk_i) begin
    if (acc && store) begin
      mem[cnt_q[AddrW-1:0]] <= in_i.data_byte;
    end
    rdata_q <= mem[raddr];
  end

  ch64_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rsp_o        (rsp),
    .byte_raddr_o (raddr),
    .byte_rdata_i (rdata_q)
  );

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    hash_d    = hash_q;
    tl_d      = tl_q;
    cmd.start = 1'b0;
    cmd.len   = cnt_after;
    if (cnt_after == '0) begin
      cmd.path = PATH_0;
    end else if (cnt_after <= LenW'(3)) begin
      cmd.path = PATH_3;
    end else if (cnt_after <= LenW'(7)) begin
      cmd.path = PATH_7;
    end else if (cnt_after <= LenW'(16)) begin
      cmd.path = PATH_16;
    end else if (cnt_after <= LenW'(32)) begin
      cmd.path = PATH_32;
    end else begin
      cmd.path = PATH_64;
    end
    case (st_q)
      ST_COLLECT: begin
        if (acc) begin
          if (in_i.last) begin
            cnt_d = '0;
            ovf_d = 1'b0;
            if (ovf_after) begin
              hash_d = 64'd0;
              tl_d   = 1'b1;
              st_d   = ST_OUT;
            end else begin
              cmd.start = 1'b1;
              st_d      = ST_HASH;
            end
          end else begin
            cnt_d = cnt_after;
            ovf_d = ovf_after;
          end
        end
      end
      ST_HASH: begin
        if (rsp.done) begin
          hash_d = rsp.hash;
          tl_d   = 1'b0;
          st_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_o.ready) begin
          st_d = ST_COLLECT;
        end
      end
      default: st_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_COLLECT;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    tl_q   <= tl_d;
  end

  assign out_o.valid      = (st_q == ST_OUT);
  assign out_o.hash_value = hash_q;
  assign out_o.too_long   = tl_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a hash word is pending");

  a_long_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.too_long |-> out_o.hash_value == 64'd0)
    else $error("overlong message with nonzero hash");

  a_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> st_q == ST_HASH)
    else $error("sequencer finished outside hashing");

  a_start_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> st_q == ST_HASH)
    else $error("start did not enter hashing");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LenW'(MaxLen))
    else $error("byte count past buffer depth");

endmodule

// ===== hdl/ch64_regfile.sv =====
// Sixteen 64-bit working registers: one write port, two registered read ports.
// Depends on ch64_pkg.
module ch64_regfile (
  input  logic              clk_i,
  input  logic              we_i,
  input  ch64_pkg::reg_t    waddr_i,
  input  logic [63:0]       wdata_i,
  input  ch64_pkg::reg_t    raddr_a_i,
  input  ch64_pkg::reg_t    raddr_b_i,
  output logic [63:0]       rdata_a_o,
  output logic [63:0]       rdata_b_o
);
  import ch64_pkg::*;

  logic [63:0] mem [16];
  logic [63:0] rdata_a_q;
  logic [63:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hdl/ch64_mul.sv =====
// 64x64 multiplier, low half of the product, built on one 32x32 unit.
// Depends on ch64_pkg.
module ch64_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);
  import ch64_pkg::*;

  logic [2:0]  step_q, step_d;
  logic [63:0] a_q, b_q, acc_q, prod_q;
  logic [31:0] mx, my;

  always_comb begin
    step_d = step_q;
    mx     = a_q[31:0];
    my     = b_q[31:0];
    case (step_q)
      3'd0: if (start_i) step_d = 3'd1;
      3'd1: step_d = 3'd2;
      3'd2: begin
        my     = b_q[63:32];
        step_d = 3'd3;
      end
      3'd3: begin
        mx     = a_q[63:32];
        step_d = 3'd4;
      end
      3'd4: step_d = 3'd0;
      default: step_d = 3'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 3'd0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_q == 3'd0 && start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    prod_q <= mx * my;
    if (step_q == 3'd2) begin
      acc_q <= prod_q;
    end else if (step_q == 3'd3) begin
      acc_q <= acc_q + {prod_q[31:0], 32'h0};
    end
  end

  assign done_o = (step_q == 3'd4);
  assign p_o    = acc_q + {prod_q[31:0], 32'h0};

endmodule

// ===== hdl/ch64_core.sv =====
// Microcoded hash sequencer: ROM-driven ALU, byte loader and shared multiplier.
// Depends on ch64_pkg, ch64_regfile and ch64_mul.
module ch64_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ch64_pkg::ch64_cmd_t             cmd_i,
  output ch64_pkg::ch64_rsp_t             rsp_o,
  output logic [ch64_pkg::AddrW-1:0]      byte_raddr_o,
  input  logic [7:0]                      byte_rdata_i
);
  import ch64_pkg::*;

  core_state_e     st_q, st_d;
  path_e           path_q, path_d;
  logic [LenW-1:0] len_q, len_d;
  logic [5:0]      pc_q, pc_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [63:0]     ld_q, ld_d;

  instr_t          ins;
  logic [63:0]     opa, opb, kval, alu_res, ld_full, ld_val, mul_p, rf_b;
  logic            mul_start, mul_done, rf_we;
  logic [63:0]     rf_wdata;
  logic [AddrW-1:0] base_a;
  logic [3:0]      ld_n;

  function automatic logic [63:0] rotl(logic [63:0] v, logic [5:0] s);
    logic [127:0] t;
    t = {v, v} << s;
    return t[127:64];
  endfunction

  function automatic logic [63:0] bswap(logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  assign ins = ucode(path_q, pc_q);

  ch64_regfile u_rf (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (ins.dst),
    .wdata_i   (rf_wdata),
    .raddr_a_i (ins.ra),
    .raddr_b_i (ins.rb),
    .rdata_a_o (opa),
    .rdata_b_o (rf_b)
  );

  ch64_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_comb begin
    case (ins.bsel)
      BK_K0:   kval = K0;
      BK_K1:   kval = K1;
      BK_K2:   kval = K2;
      BK_C1:   kval = 64'd1;
      BK_C4:   kval = 64'd4;
      BK_C8:   kval = 64'd8;
      BK_C9:   kval = 64'd9;
      BK_C256: kval = 64'd256;
      BK_LEN:  kval = 64'(len_q);
      default: kval = 64'd0;
    endcase
  end

  assign opb = (ins.bsel == BK_REG) ? rf_b : kval;

  always_comb begin
    case (ins.op)
      OP_ADD:   alu_res = opa + opb;
      OP_XOR:   alu_res = opa ^ opb;
      OP_ROT:   alu_res = rotl(opa, ins.rot);
      OP_SMIX:  alu_res = opa ^ (opa >> 47);
      OP_BSWAP: alu_res = bswap(opa);
      OP_MOVB:  alu_res = opb;
      default:  alu_res = opa;
    endcase
  end

  assign ld_full = {byte_rdata_i, ld_q[63:8]};

  always_comb begin
    case (ins.lsz)
      LSZ_1: begin
        ld_val = 64'(ld_full[63:56]);
        ld_n   = 4'd1;
      end
      LSZ_4: begin
        ld_val = 64'(ld_full[63:32]);
        ld_n   = 4'd4;
      end
      default: begin
        ld_val = ld_full;
        ld_n   = 4'd8;
      end
    endcase
    case (ins.base)
      BASE_LEN:  base_a = len_q[AddrW-1:0];
      BASE_HALF: base_a = len_q[AddrW:1];
      default:   base_a = '0;
    endcase
  end

  assign byte_raddr_o = base_a + ins.off[AddrW-1:0] + AddrW'(cnt_q);

  always_comb begin
    st_d       = st_q;
    path_d     = path_q;
    len_d      = len_q;
    pc_d       = pc_q;
    cnt_d      = cnt_q;
    ld_d       = ld_q;
    rf_we      = 1'b0;
    rf_wdata   = alu_res;
    mul_start  = 1'b0;
    rsp_o.done = 1'b0;
    rsp_o.hash = opa;
    case (st_q)
      CS_IDLE: begin
        if (cmd_i.start) begin
          path_d = cmd_i.path;
          len_d  = cmd_i.len;
          pc_d   = 6'd0;
          st_d   = CS_FETCH;
        end
      end
      CS_FETCH: begin
        cnt_d = 4'd0;
        st_d  = (ins.op == OP_LD) ? CS_LOAD : CS_EXEC;
      end
      CS_EXEC: begin
        case (ins.op)
          OP_MUL: begin
            mul_start = 1'b1;
            st_d      = CS_MUL;
          end
          OP_DONE: begin
            rsp_o.done = 1'b1;
            st_d       = CS_IDLE;
          end
          default: begin
            rf_we = 1'b1;
            pc_d  = pc_q + 6'd1;
            st_d  = CS_FETCH;
          end
        endcase
      end
      CS_MUL: begin
        if (mul_done) begin
          rf_we    = 1'b1;
          rf_wdata = mul_p;
          pc_d     = pc_q + 6'd1;
          st_d     = CS_FETCH;
        end
      end
      CS_LOAD: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q != 4'd0) begin
          ld_d = ld_full;
        end
        if (cnt_q == ld_n) begin
          rf_we    = 1'b1;
          rf_wdata = ld_val;
          pc_d     = pc_q + 6'd1;
          st_d     = CS_FETCH;
        end
      end
      default: st_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= CS_IDLE;
      path_q <= PATH_0;
      len_q  <= '0;
      pc_q   <= 6'd0;
      cnt_q  <= 4'd0;
    end else begin
      st_q   <= st_d;
      path_q <= path_d;
      len_q  <= len_d;
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_q <= ld_d;
  end

endmodule
